// File: sv/asp_pkg.sv
// Shared types, widths and helper functions for the adaptive share apportioner.
// Used by asp_ctrl, asp_datapath and adaptive_share_apportioner.
package asp_pkg;

  localparam int TASK_COUNT = 4;
  localparam int SHARE_W    = 7;
  localparam int PEAK_W     = 32;
  localparam int CFG_IDX_W  = 8;

  localparam int IDX_W      = $clog2(TASK_COUNT);
  localparam int BL_W       = $clog2(PEAK_W + 1);
  localparam int SHARE_MAX  = (1 << SHARE_W) - 1;
  localparam int IDEAL_MAX  = SHARE_MAX - 1 + PEAK_W;
  localparam int IDEAL_W    = $clog2(IDEAL_MAX + 1);
  localparam int SUM_W      = $clog2(TASK_COUNT * IDEAL_MAX + 1);
  localparam int DEN_W      = SUM_W + 1;
  localparam int NUM_W      = $clog2(2 * SHARE_MAX * IDEAL_MAX + TASK_COUNT * IDEAL_MAX + 1);
  // quotient never exceeds total_share, so SHARE_W quotient bits suffice
  localparam int TRIAL_W    = DEN_W + SHARE_W - 1;
  localparam int BIT_W      = $clog2(SHARE_W);
  localparam int GOT_W      = $clog2(TASK_COUNT * SHARE_MAX + 1);
  localparam int DIFF_W     = GOT_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SHARE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SHARE_EN = CFG_IDX_W'(1);

  localparam logic [SHARE_W-1:0] TOTAL_RESET = SHARE_W'(32);

  typedef logic [SHARE_W-1:0] share_t;
  typedef logic [PEAK_W-1:0]  peak_t;

  typedef struct packed {
    logic             capture;
    logic             ideal_en;
    logic             load;
    logic             div_en;
    logic             div_last;
    logic             diff_en;
    logic             fix_en;
    logic [IDX_W-1:0] idx;
    logic [BIT_W-1:0] bit_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic diff_zero;
    logic pass_moved;
  } dp_status_t;

  // position of the highest set bit plus one; zero for zero
  function automatic logic [BL_W-1:0] bit_len(input logic [PEAK_W-1:0] v);
    logic [BL_W-1:0] n;
    n = '0;
    for (int i = 0; i < PEAK_W; i++) begin
      if (v[i]) n = BL_W'(i + 1);
    end
    return n;
  endfunction

endpackage

// File: sv/asp_datapath.sv
// Datapath: ideal shares, shared restoring divider, and correction passes.
// Depends on asp_pkg; driven by asp_ctrl through dp_cmd_t.
module asp_datapath (
  input  logic                clk,
  input  asp_pkg::dp_cmd_t    cmd,
  output asp_pkg::dp_status_t status,
  input  asp_pkg::share_t     total,
  input  logic                min_en,
  input  asp_pkg::share_t     cur_in  [asp_pkg::TASK_COUNT],
  input  asp_pkg::peak_t      peak_in [asp_pkg::TASK_COUNT],
  output asp_pkg::share_t     share_out [asp_pkg::TASK_COUNT]
);
  import asp_pkg::*;

  share_t                    cur   [TASK_COUNT];
  peak_t                     peak  [TASK_COUNT];
  logic [IDEAL_W-1:0]        ideal [TASK_COUNT];
  share_t                    share [TASK_COUNT];
  logic [SUM_W-1:0]          sum;
  logic [NUM_W-1:0]          rem;
  share_t                    quo;
  logic [GOT_W-1:0]          got;
  logic signed [DIFF_W-1:0]  diff;
  logic                      moved;

  logic [BL_W-1:0]    bl;
  logic [IDEAL_W-1:0] cur_plus;
  logic [IDEAL_W-1:0] ideal_new;
  logic [NUM_W-1:0]   prod;
  logic [NUM_W-1:0]   num_load;
  logic [DEN_W-1:0]   den;
  logic [TRIAL_W-1:0] trial;
  logic [TRIAL_W-1:0] rem_ext;
  logic               fit;
  logic [NUM_W-1:0]   rem_next;
  share_t             quo_next;
  share_t             cur_sh;
  logic               up;
  logic               down;
  logic               moved_acc;

  always_comb begin
    bl        = bit_len(peak[cmd.idx]);
    cur_plus  = IDEAL_W'(cur[cmd.idx]) + IDEAL_W'(bl);
    ideal_new = (cur_plus < IDEAL_W'(2)) ? IDEAL_W'(1) : cur_plus - IDEAL_W'(1);

    // round half up: (2*total*ideal + sum) / (2*sum)
    prod      = NUM_W'(total) * NUM_W'(ideal[cmd.idx]);
    num_load  = (prod << 1) + NUM_W'(sum);
    den       = {sum, 1'b0};
    trial     = TRIAL_W'(den) << cmd.bit_idx;
    rem_ext   = TRIAL_W'(rem);
    fit       = rem_ext >= trial;
    rem_next  = fit ? NUM_W'(rem_ext - trial) : rem;
    quo_next  = quo | (fit ? (SHARE_W'(1) << cmd.bit_idx) : '0);

    cur_sh    = share[cmd.idx];
    up        = !diff[DIFF_W-1] && (diff != '0) && (!min_en || cur_sh != '0);
    down      = diff[DIFF_W-1] && (cur_sh > SHARE_W'(1));
    moved_acc = ((cmd.idx == '0) ? 1'b0 : moved) | up | down;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < TASK_COUNT; i++) begin
        cur[i]  <= cur_in[i];
        peak[i] <= peak_in[i];
      end
      sum <= '0;
      got <= '0;
    end
    if (cmd.ideal_en) begin
      ideal[cmd.idx] <= ideal_new;
      sum            <= sum + SUM_W'(ideal_new);
    end
    if (cmd.load) begin
      rem <= num_load;
      quo <= '0;
    end
    if (cmd.div_en) begin
      rem <= rem_next;
      quo <= quo_next;
      if (cmd.div_last) begin
        share[cmd.idx] <= quo_next;
        got            <= got + GOT_W'(quo_next);
      end
    end
    if (cmd.diff_en) begin
      diff <= $signed(DIFF_W'(total)) - $signed(DIFF_W'(got));
    end
    if (cmd.fix_en) begin
      moved <= moved_acc;
      if (up) begin
        share[cmd.idx] <= cur_sh + SHARE_W'(1);
        diff           <= diff - DIFF_W'(1);
      end else if (down) begin
        share[cmd.idx] <= cur_sh - SHARE_W'(1);
        diff           <= diff + DIFF_W'(1);
      end
    end
  end

  assign status.diff_zero  = (diff == '0);
  assign status.pass_moved = moved_acc;

  always_comb begin
    for (int i = 0; i < TASK_COUNT; i++) share_out[i] = share[i];
  end

endmodule

// File: sv/asp_ctrl.sv
// Controller state machine: sequences ideal, divide and correction steps.
// Depends on asp_pkg; drives asp_datapath through dp_cmd_t.
module asp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output asp_pkg::dp_cmd_t    cmd,
  input  asp_pkg::dp_status_t status
);
  import asp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_IDEAL = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_DIFF  = 7'b0010000,
    S_FIX   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_COUNT - 1);
  localparam logic [BIT_W-1:0] BIT_TOP  = BIT_W'(SHARE_W - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [BIT_W-1:0] bit_idx, bit_idx_next;

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    bit_idx_next = bit_idx;
    cmd          = '0;
    cmd.idx      = idx;
    cmd.bit_idx  = bit_idx;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          idx_next    = '0;
          state_next  = S_IDEAL;
        end
      end
      S_IDEAL: begin
        cmd.ideal_en = 1'b1;
        if (idx == IDX_LAST) begin
          idx_next   = '0;
          state_next = S_LOAD;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      S_LOAD: begin
        cmd.load     = 1'b1;
        bit_idx_next = BIT_TOP;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        if (bit_idx == '0) begin
          cmd.div_last = 1'b1;
          if (idx == IDX_LAST) begin
            idx_next   = '0;
            state_next = S_DIFF;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = S_LOAD;
          end
        end else begin
          bit_idx_next = bit_idx - BIT_W'(1);
        end
      end
      S_DIFF: begin
        cmd.diff_en = 1'b1;
        idx_next    = '0;
        state_next  = S_FIX;
      end
      S_FIX: begin
        if (status.diff_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.fix_en = 1'b1;
          if (idx == IDX_LAST) begin
            idx_next = '0;
            // a full pass that moved nothing means correction is stuck
            if (!status.pass_moved) state_next = S_DONE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      bit_idx <= '0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      bit_idx <= bit_idx_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// File: sv/adaptive_share_apportioner.sv
// From start to done the block runs its ideal, divide, difference and
// correction steps in order (correction visits one task per cycle); the shared
// 7-step restoring divider, run once per task, takes most of that time.
// A new item cannot be taken while one is in progress; start is taken
// whenever busy is low, in the cycle after done; the receiver cannot stall.
// Reset: total_share = 32, min_share_enable = 1, controller idle.
// done is a one-cycle strobe; results hold until the next item rewrites them.
module adaptive_share_apportioner (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  output logic                           done,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [asp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asp_pkg::SHARE_W-1:0]    cfg_data,
  input  logic [asp_pkg::SHARE_W-1:0]    cur_share_0,
  input  logic [asp_pkg::SHARE_W-1:0]    cur_share_1,
  input  logic [asp_pkg::SHARE_W-1:0]    cur_share_2,
  input  logic [asp_pkg::SHARE_W-1:0]    cur_share_3,
  input  logic [asp_pkg::PEAK_W-1:0]     peak_0,
  input  logic [asp_pkg::PEAK_W-1:0]     peak_1,
  input  logic [asp_pkg::PEAK_W-1:0]     peak_2,
  input  logic [asp_pkg::PEAK_W-1:0]     peak_3,
  output logic [asp_pkg::SHARE_W-1:0]    new_share_0,
  output logic [asp_pkg::SHARE_W-1:0]    new_share_1,
  output logic [asp_pkg::SHARE_W-1:0]    new_share_2,
  output logic [asp_pkg::SHARE_W-1:0]    new_share_3
);
  import asp_pkg::*;

  share_t     total_share;
  logic       min_share_enable;
  dp_cmd_t    cmd;
  dp_status_t status;
  share_t     cur_in    [TASK_COUNT];
  peak_t      peak_in   [TASK_COUNT];
  share_t     share_out [TASK_COUNT];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_share      <= TOTAL_RESET;
      min_share_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TOTAL_SHARE) begin
        total_share <= cfg_data;
      end else if (cfg_index == REG_MIN_SHARE_EN) begin
        min_share_enable <= cfg_data[0];
      end
    end
  end

  assign cur_in[0]  = cur_share_0;
  assign cur_in[1]  = cur_share_1;
  assign cur_in[2]  = cur_share_2;
  assign cur_in[3]  = cur_share_3;
  assign peak_in[0] = peak_0;
  assign peak_in[1] = peak_1;
  assign peak_in[2] = peak_2;
  assign peak_in[3] = peak_3;

  asp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  asp_datapath u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .status    (status),
    .total     (total_share),
    .min_en    (min_share_enable),
    .cur_in    (cur_in),
    .peak_in   (peak_in),
    .share_out (share_out)
  );

  assign new_share_0 = share_out[0];
  assign new_share_1 = share_out[1];
  assign new_share_2 = share_out[2];
  assign new_share_3 = share_out[3];

endmodule

// File: bench/asp_checker.sv
// Checker for the adaptive share apportioner: watches the config channel,
// the start/busy handshake and the done strobe, and scores every new share.
// Depends on asp_pkg for widths and register indexes.
module asp_checker (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  start,
  input  logic                                                  busy,
  input  logic                                                  done,
  input  logic                                                  cfg_valid,
  input  logic                                                  cfg_ready,
  input  logic [asp_pkg::CFG_IDX_W-1:0]                         cfg_index,
  input  logic [asp_pkg::SHARE_W-1:0]                           cfg_data,
  input  logic [asp_pkg::TASK_COUNT-1:0][asp_pkg::SHARE_W-1:0]  cur,
  input  logic [asp_pkg::TASK_COUNT-1:0][asp_pkg::PEAK_W-1:0]   peak,
  input  logic [asp_pkg::TASK_COUNT-1:0][asp_pkg::SHARE_W-1:0]  result,
  output int                                                    alloc_pending,
  output int                                                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import asp_pkg::*;

  typedef logic [TASK_COUNT-1:0][SHARE_W-1:0] share_vec_t;
  typedef logic [TASK_COUNT-1:0][PEAK_W-1:0]  peak_vec_t;

  int         cfg_total;
  bit         cfg_min_en;
  share_vec_t alloc_q[$];

  initial begin
    fail_count    = 0;
    alloc_pending = 0;
    cfg_total     = int'(TOTAL_RESET);
    cfg_min_en    = 1'b1;
  end

  task automatic flag(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Proportional split with round-half-up, then index-order touch-up passes.
  function automatic share_vec_t apportion(input share_vec_t cs, input peak_vec_t pk,
                                           input int total, input bit min_en);
    int         ideal[TASK_COUNT];
    int         share[TASK_COUNT];
    int         sum;
    int         got;
    int         diff;
    int         len;
    bit         moved;
    share_vec_t res;
    sum = 0;
    for (int i = 0; i < TASK_COUNT; i++) begin
      len = 0;
      for (int b = 0; b < PEAK_W; b++) begin
        if (pk[i][b]) len = b + 1;
      end
      ideal[i] = int'(cs[i]) - 1 + len;
      if (ideal[i] < 1) ideal[i] = 1;
      sum += ideal[i];
    end
    got = 0;
    for (int i = 0; i < TASK_COUNT; i++) begin
      share[i] = (2 * total * ideal[i] + sum) / (2 * sum);
      got += share[i];
    end
    diff = total - got;
    while (diff != 0) begin
      moved = 1'b0;
      for (int i = 0; i < TASK_COUNT && diff != 0; i++) begin
        if (diff > 0 && (!min_en || share[i] > 0)) begin
          share[i]++;
          diff--;
          moved = 1'b1;
        end else if (diff < 0 && share[i] > 1) begin
          share[i]--;
          diff++;
          moved = 1'b1;
        end
      end
      // stuck shortfall or stuck excess: leave shares as they stand
      if (!moved) break;
    end
    for (int i = 0; i < TASK_COUNT; i++) res[i] = share[i][SHARE_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    share_vec_t want;
    if (rst) begin
      cfg_total  = int'(TOTAL_RESET);
      cfg_min_en = 1'b1;
      alloc_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TOTAL_SHARE:  cfg_total  = int'(cfg_data);
          REG_MIN_SHARE_EN: cfg_min_en = cfg_data[0];
          default: ;
        endcase
      end
      if (done) begin
        if (alloc_q.size() == 0) begin
          flag("done strobe with no transaction outstanding");
        end else begin
          want = alloc_q.pop_front();
          for (int i = 0; i < TASK_COUNT; i++) begin
            if (result[i] !== want[i])
              flag($sformatf("new_share_%0d = %0d, want %0d", i, result[i], want[i]));
          end
        end
      end
      if (start && !busy) alloc_q.push_back(apportion(cur, peak, cfg_total, cfg_min_en));
    end
    alloc_pending = alloc_q.size();
  end

endmodule

// File: bench/tb_top.sv
// Top of the apportioner bench: clock, reset, register setup and item traffic.
// Depends on asp_pkg, asp_checker and the adaptive_share_apportioner RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import asp_pkg::*;

  typedef logic [TASK_COUNT-1:0][SHARE_W-1:0] share_vec_t;
  typedef logic [TASK_COUNT-1:0][PEAK_W-1:0]  peak_vec_t;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 16;
  localparam int PER_PHASE   = 100;
  localparam int FIXED_CFGS  = 9;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 done;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  share_t               cfg_data = '0;
  share_vec_t           cur_v = '0;
  peak_vec_t            peak_v = '0;
  share_t               new_share_0, new_share_1, new_share_2, new_share_3;

  int alloc_pending;
  int fail_count;
  int cycles = 0;
  int sent = 0;

  // edge totals first: tiny ones hit the stuck shortfall/excess paths
  int fixed_total[FIXED_CFGS] = '{4, 64, 0, 1, 2, 127, 5, 3, 63};

  always #4 clk = ~clk;

  adaptive_share_apportioner uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cur_share_0(cur_v[0]), .cur_share_1(cur_v[1]),
    .cur_share_2(cur_v[2]), .cur_share_3(cur_v[3]),
    .peak_0(peak_v[0]), .peak_1(peak_v[1]), .peak_2(peak_v[2]), .peak_3(peak_v[3]),
    .new_share_0(new_share_0), .new_share_1(new_share_1),
    .new_share_2(new_share_2), .new_share_3(new_share_3)
  );

  asp_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cur(cur_v), .peak(peak_v),
    .result({new_share_3, new_share_2, new_share_1, new_share_0}),
    .alloc_pending(alloc_pending), .fail_count(fail_count)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: no progress after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // sender gaps: about a third of the time, none in the steady window
  function automatic bit want_gap();
    if (sent >= 700 && sent < 1000) return 1'b0;
    return $urandom_range(0, 99) < 33;
  endfunction

  task automatic drive_item(input share_vec_t cs, input peak_vec_t pk);
    @(negedge clk);
    if (want_gap()) begin
      start = 1'b0;
      // idle only once the block is free, so the gap shows at the port
      while (busy) @(negedge clk);
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    cur_v  = cs;
    peak_v = pk;
    start  = 1'b1;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input share_t data);
    @(negedge clk);
    if ($urandom_range(0, 99) < 33) repeat ($urandom_range(1, 4)) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (alloc_pending != 0) @(posedge clk);
  endtask

  task automatic rand_item(output share_vec_t cs, output peak_vec_t pk);
    int     mode;
    int     r;
    share_t c_all;
    peak_t  p_all;
    mode  = $urandom_range(0, 99);
    c_all = share_t'($urandom_range(0, 127));
    p_all = $urandom >> $urandom_range(0, 32);
    for (int i = 0; i < TASK_COUNT; i++) begin
      if (mode < 10) begin
        // equal ideals on every task
        cs[i] = c_all;
        pk[i] = p_all;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65)      cs[i] = share_t'($urandom_range(0, 64));
        else if (r < 85) cs[i] = share_t'($urandom_range(0, 127));
        else if (r < 92) cs[i] = '0;
        else if (r < 96) cs[i] = share_t'(1);
        else             cs[i] = '1;
        r = $urandom_range(0, 99);
        if (r < 75)      pk[i] = $urandom >> $urandom_range(0, 32);
        else if (r < 85) pk[i] = '0;
        else if (r < 90) pk[i] = '1;
        else             pk[i] = $urandom;
      end
    end
  endtask

  initial begin
    share_vec_t cs;
    peak_vec_t  pk;
    int         total;
    share_t     en_word;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed items under reset settings
    drive_item({4{7'd0}}, {4{32'd0}});
    drive_item({4{7'd127}}, {4{32'hFFFF_FFFF}});
    drive_item({7'd127, 7'd0, 7'd127, 7'd0},
               {32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd0});
    drive_item({7'd0, 7'd0, 7'd0, 7'd1}, {32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0});
    drive_item({4{7'd64}}, {32'd8, 32'd4, 32'd2, 32'd1});
    drive_item({7'd0, 7'd0, 7'd0, 7'd127}, {4{32'd0}});
    drive_item({7'h2A, 7'h55, 7'h2A, 7'h55},
               {32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
    drive_item({7'd1, 7'd2, 7'd3, 7'd4}, {32'd0, 32'd1, 32'd3, 32'd7});

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        if (p <= FIXED_CFGS) begin
          total = fixed_total[p-1];
        end else begin
          case ($urandom_range(0, 4))
            0:       total = $urandom_range(0, 3);
            1:       total = $urandom_range(65, 127);
            default: total = $urandom_range(4, 64);
          endcase
        end
        en_word    = share_t'($urandom);
        en_word[0] = (p <= FIXED_CFGS) ? p[0] : 1'($urandom_range(0, 1));
        write_reg(REG_TOTAL_SHARE, share_t'(total));
        write_reg(REG_MIN_SHARE_EN, en_word);
        // unmapped index must leave both registers alone
        write_reg(CFG_IDX_W'($urandom_range(2, (1 << CFG_IDX_W) - 1)), share_t'($urandom));
      end
      for (int k = 0; k < PER_PHASE; k++) begin
        rand_item(cs, pk);
        drive_item(cs, pk);
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
